>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also applies while reset is asserted.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/ptc_pkg.sv
// Shared types and constants of the prefix-code tree decoder.
// No dependencies.
package ptc_pkg;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                symbol_valid;
        logic [SYM_W-1:0]    decoded_symbol;
    } t_result;

endpackage

>>> rtl/ptc_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on ptc_pkg.
interface ptc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [ptc_pkg::SYM_W-1:0]      symbol;
    logic [ptc_pkg::CODE_W-1:0]     code_bits;
    logic [ptc_pkg::LEN_W-1:0]      code_length;
    logic                           coded_bit;

    modport source (output valid, func, symbol, code_bits, code_length, coded_bit,
                    input ready);
    modport sink   (input valid, func, symbol, code_bits, code_length, coded_bit,
                    output ready);
endinterface

interface ptc_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptc_pkg::STATUS_W-1:0]   status;
    logic                           symbol_valid;
    logic [ptc_pkg::SYM_W-1:0]      decoded_symbol;

    modport source (output valid, status, symbol_valid, decoded_symbol, input ready);
    modport sink   (input valid, status, symbol_valid, decoded_symbol, output ready);
endinterface

>>> rtl/prefix_code_tree_decoder_top.sv
// Top level of the prefix-code tree decoder: node-table RAM, walk sequencer,
// result register. Depends on ptc_pkg, ptc_if, ptc_ram and ptc_ctrl.
//
//   Channel  Dir  Payload                                   Handshake
//   i_in     in   func, symbol, code_bits, code_length,     valid/ready
//                 coded_bit
//   o_out    out  status, symbol_valid, decoded_symbol      valid/ready
//
// One transaction at a time, serialized on the node-table RAM (one read and one write port).
// Decode reads the current node, then its child if present. Load walks from the root,
// writing parent then fresh node per new node; unused entries are never read.
// Reset clears state, current node, root-written and fresh flags; node count becomes one.
// A waiting result does not block acceptance; a second result waits for the register.
module prefix_code_tree_decoder_top #(
    parameter int NODES           = 512,
    parameter int MAX_CODE_LENGTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptc_in_if.sink    i_in,
    ptc_out_if.source o_out
);
    import ptc_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int EW = 2 * IW + 2 + SYM_W;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [IW-1:0] raddr;
    logic [EW-1:0] rdata;
    logic          done;
    logic          out_free;
    t_result       res;
    logic          r_valid;
    t_result       r_out;

    ptc_ram #(
        .WIDTH (EW),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ptc_ctrl #(
        .NODES           (NODES),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res)
    );

    assign out_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_out.status;
    assign o_out.symbol_valid   = r_out.symbol_valid;
    assign o_out.decoded_symbol = r_out.decoded_symbol;

endmodule

>>> rtl/ptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptc_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ptc_ctrl.sv
// Tree walk sequencer: load walks and node creation, decode steps.
// Depends on ptc_pkg and ptc_if; drives the node-table RAM ports.
module ptc_ctrl #(
    parameter int NODES           = 512,
    parameter int MAX_CODE_LENGTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ptc_in_if.sink                                 i_in,
    output logic                                   o_we,
    output logic [$clog2(NODES)-1:0]               o_waddr,
    output logic [2*$clog2(NODES)+2+ptc_pkg::SYM_W-1:0] o_wdata,
    output logic [$clog2(NODES)-1:0]               o_raddr,
    input  logic [2*$clog2(NODES)+2+ptc_pkg::SYM_W-1:0] i_rdata,
    input  logic                                   i_out_free,
    output logic                                   o_done,
    output ptc_pkg::t_result                       o_res
);
    import ptc_pkg::*;

    localparam int IW   = $clog2(NODES);
    localparam int UW   = $clog2(NODES + 1);
    localparam int EW   = 2 * IW + 2 + SYM_W;
    localparam int LP   = IW;
    localparam int RLO  = IW + 1;
    localparam int RP   = 2 * IW + 1;
    localparam int SLO  = 2 * IW + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EV   = 4'd1;
    localparam logic [3:0] S_WRP  = 4'd2;
    localparam logic [3:0] S_WRF  = 4'd3;
    localparam logic [3:0] S_DEV  = 4'd4;
    localparam logic [3:0] S_CEV  = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;

    logic [3:0]        r_state, n_state;
    logic [IW-1:0]     r_cur, n_cur;
    logic [UW-1:0]     r_used, n_used;
    logic              r_root_wr, n_root_wr;
    logic              r_fresh, n_fresh;
    logic [IW-1:0]     r_node, n_node;
    logic [EW-1:0]     r_ent, n_ent;
    logic              r_func, n_func;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [CODE_W-1:0] r_bits, n_bits;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_i, n_i;
    logic              r_dbit, n_dbit;
    logic              r_dir, n_dir;
    t_result           r_res, n_res;

    logic [EW-1:0]     ent_rd;
    logic              code_bit;
    logic              sel_bit;
    logic              pres;
    logic [IW-1:0]     child;
    logic [IW-1:0]     fresh;
    logic [LEN_W-1:0]  len_clamp;

    assign ent_rd    = (r_fresh || (r_node == '0 && !r_root_wr)) ? '0 : i_rdata;
    assign code_bit  = (r_i < LEN_W'(CODE_W)) ? r_bits[r_i[$clog2(CODE_W)-1:0]] : 1'b0;
    assign sel_bit   = (r_func == FUNC_DECODE) ? r_dbit : code_bit;
    assign pres      = sel_bit ? ent_rd[RP] : ent_rd[LP];
    assign child     = sel_bit ? ent_rd[RP-1:RLO] : ent_rd[IW-1:0];
    assign fresh     = r_used[IW-1:0];
    assign len_clamp = ({1'b0, i_in.code_length} > (LEN_W + 1)'(MAX_CODE_LENGTH))
                       ? LEN_W'(MAX_CODE_LENGTH) : i_in.code_length;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_used    = r_used;
        n_root_wr = r_root_wr;
        n_fresh   = r_fresh;
        n_node    = r_node;
        n_ent     = r_ent;
        n_func    = r_func;
        n_sym     = r_sym;
        n_bits    = r_bits;
        n_len     = r_len;
        n_i       = r_i;
        n_dbit    = r_dbit;
        n_dir     = r_dir;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_node;
        o_wdata   = r_ent;
        o_raddr   = r_node;
        o_done    = 1'b0;
        i_in.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.func == FUNC_DECODE) begin
                    o_raddr = r_cur;
                end else begin
                    o_raddr = '0;
                end
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_sym   = i_in.symbol;
                    n_bits  = i_in.code_bits;
                    n_len   = len_clamp;
                    n_dbit  = i_in.coded_bit;
                    n_i     = '0;
                    n_fresh = 1'b0;
                    n_res   = '0;
                    if (i_in.func == FUNC_DECODE) begin
                        n_node  = r_cur;
                        n_state = S_DEV;
                    end else begin
                        n_node  = '0;
                        n_state = S_EV;
                    end
                end
            end
            S_EV: begin
                n_ent = ent_rd;
                if (r_i == r_len) begin
                    o_we    = 1'b1;
                    o_wdata = {r_sym, ent_rd[SLO-1:0]};
                    if (r_node == '0) begin
                        n_root_wr = 1'b1;
                    end
                    n_res.status = STATUS_OK;
                    n_state      = S_OUT;
                end else if (pres) begin
                    o_raddr = child;
                    n_node  = child;
                    n_i     = r_i + 1'b1;
                    n_fresh = 1'b0;
                end else if (r_used == UW'(NODES)) begin
                    n_res.status = STATUS_FULL;
                    n_state      = S_OUT;
                end else begin
                    n_dir   = code_bit;
                    n_state = S_WRP;
                end
            end
            S_WRP: begin
                o_we = 1'b1;
                if (r_dir) begin
                    o_wdata = {r_ent[EW-1:SLO], 1'b1, fresh, r_ent[LP:0]};
                end else begin
                    o_wdata = {r_ent[EW-1:LP+1], 1'b1, fresh};
                end
                if (r_node == '0) begin
                    n_root_wr = 1'b1;
                end
                n_state = S_WRF;
            end
            S_WRF: begin
                o_we    = 1'b1;
                o_waddr = fresh;
                o_wdata = '0;
                n_node  = fresh;
                n_used  = r_used + 1'b1;
                n_i     = r_i + 1'b1;
                n_fresh = 1'b1;
                n_state = S_EV;
            end
            S_DEV: begin
                if (!pres) begin
                    n_res.status = STATUS_MISSING;
                    n_cur        = '0;
                    n_state      = S_OUT;
                end else begin
                    o_raddr = child;
                    n_node  = child;
                    n_state = S_CEV;
                end
            end
            S_CEV: begin
                if (!ent_rd[LP] && !ent_rd[RP]) begin
                    n_res.symbol_valid   = 1'b1;
                    n_res.decoded_symbol = ent_rd[EW-1:SLO];
                    n_cur                = '0;
                end else begin
                    n_cur = r_node;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_used    <= UW'(1);
            r_root_wr <= 1'b0;
            r_fresh   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_used    <= n_used;
            r_root_wr <= n_root_wr;
            r_fresh   <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_ent  <= n_ent;
        r_func <= n_func;
        r_sym  <= n_sym;
        r_bits <= n_bits;
        r_len  <= n_len;
        r_i    <= n_i;
        r_dbit <= n_dbit;
        r_dir  <= n_dir;
        r_res  <= n_res;
    end

    assign o_res = r_res;

endmodule

>>> rtl/ptc_checker.sv
// Port-level checks of the prefix-code tree decoder, bound to the top level.
// Depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ptc_pkg::STATUS_W-1:0] i_status,
    input logic                         i_symbol_valid,
    input logic [ptc_pkg::SYM_W-1:0]    i_decoded_symbol
);
    import ptc_pkg::*;

    `CHK_NEXT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n, !i_out_valid)

    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    `CHK_IMPL(a_status_code, i_clk, i_rst_n, i_out_valid, i_status != 2'd3)

    `CHK_IMPL(a_symbol_only_ok, i_clk, i_rst_n, i_out_valid && i_symbol_valid, i_status == STATUS_OK)

    `CHK_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_symbol_valid) && $stable(i_decoded_symbol))

endmodule

bind prefix_code_tree_decoder_top ptc_checker u_ptc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_symbol_valid   (o_out.symbol_valid),
    .i_decoded_symbol (o_out.decoded_symbol)
);
